// File: hdl/cartridge_bank_irq_counter_assert.svh
// Assertion macros shared by the cartridge bank IRQ counter RTL.
`ifndef CARTRIDGE_BANK_IRQ_COUNTER_ASSERT_SVH
`define CARTRIDGE_BANK_IRQ_COUNTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CBIC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CBIC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/cbic_pkg.sv
package cbic_pkg;

	localparam int CMD_W = 2;
	localparam int ADDR_W = 16;
	localparam int DATA_W = 8;
	localparam int REGION_W = 2;
	localparam int MAPPED_W = 22;
	localparam int SIZE_LOG2_W = 4;
	localparam int CNT_W = 16;
	localparam int BANK_SEL_W = 3;
	localparam int BANK_SHIFT = 14;
	localparam int RAM_OFFSET_W = 13;

	localparam int MAX_BANKS_LOG2_DEF = 8;
	localparam logic [SIZE_LOG2_W-1:0] PRG_SIZE_LOG2_RST = 4'd3;

	localparam logic [CMD_W-1:0] CMD_READ = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

	localparam logic [REGION_W-1:0] REGION_NONE = 2'd0;
	localparam logic [REGION_W-1:0] REGION_RAM = 2'd1;
	localparam logic [REGION_W-1:0] REGION_ROM = 2'd2;

	localparam logic [3:0] SEL_LATCH0 = 4'h8;
	localparam logic [3:0] SEL_LATCH1 = 4'h9;
	localparam logic [3:0] SEL_LATCH2 = 4'hA;
	localparam logic [3:0] SEL_LATCH3 = 4'hB;
	localparam logic [3:0] SEL_CONTROL = 4'hC;
	localparam logic [3:0] SEL_ACK = 4'hD;
	localparam logic [3:0] SEL_UNUSED = 4'hE;
	localparam logic [3:0] SEL_BANK = 4'hF;

	localparam int CTRL_ENABLE_AFTER_ACK = 0;
	localparam int CTRL_COUNTING = 1;
	localparam int CTRL_BYTE_MODE = 2;

endpackage

// File: hdl/cartridge_bank_irq_counter.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  cmd, cpu_addr, wdata
// out       output     out_valid / out_stall region, mapped_addr, irq_line
// cfg       input      cfg_valid / cfg_ready cfg_data (prg_size_log2)
//
// Every item passes the input register and then the result register from input transfer to result,
// and one item can be taken every cycle while the input side does not stall.
// The decode and IRQ counter update sit between the input register and the result register.
// The input side stalls only when the input register is full and the result register is held.
// Reset clears all mapper state and sets the ROM size to eight banks; cfg_ready is always high.
`include "cartridge_bank_irq_counter_assert.svh"

module cartridge_bank_irq_counter #(
	parameter int MAX_BANKS_LOG2 = cbic_pkg::MAX_BANKS_LOG2_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [cbic_pkg::CMD_W-1:0]        cmd,
	input  logic [cbic_pkg::ADDR_W-1:0]       cpu_addr,
	input  logic [cbic_pkg::DATA_W-1:0]       wdata,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [cbic_pkg::REGION_W-1:0]     region,
	output logic [cbic_pkg::MAPPED_W-1:0]     mapped_addr,
	output logic                              irq_line,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cbic_pkg::SIZE_LOG2_W-1:0]  cfg_data
);
	import cbic_pkg::*;

	logic                    valid_s1;
	logic [CMD_W-1:0]        cmd_s1;
	logic [ADDR_W-1:0]       addr_s1;
	logic [DATA_W-1:0]       wdata_s1;

	logic                    valid_s2;
	logic [REGION_W-1:0]     region_s2;
	logic [MAPPED_W-1:0]     mapped_s2;
	logic                    irq_s2;

	logic [SIZE_LOG2_W-1:0]  prg_size_log2_q;
	logic [CNT_W-1:0]        reload_latch_q;
	logic [CNT_W-1:0]        irq_counter_q;
	logic                    counting_on_q;
	logic                    enable_after_ack_q;
	logic                    byte_mode_q;
	logic [BANK_SEL_W-1:0]   bank_select_q;
	logic                    irq_pending_q;

	logic                    advance;
	logic                    fire;
	logic                    in_xfer;
	logic [SIZE_LOG2_W-1:0]  size_lg;
	logic [MAX_BANKS_LOG2-1:0] bank_mask;
	logic [MAX_BANKS_LOG2-1:0] bank_ext;
	logic [3:0]              sel;
	logic [7:0]              lo_inc;
	logic [CNT_W-1:0]        full_inc;

	logic [REGION_W-1:0]     region_d;
	logic [MAPPED_W-1:0]     mapped_d;
	logic [CNT_W-1:0]        latch_d;
	logic [CNT_W-1:0]        counter_d;
	logic                    counting_d;
	logic                    enable_after_ack_d;
	logic                    byte_mode_d;
	logic [BANK_SEL_W-1:0]   bank_select_d;
	logic                    pending_d;

	assign advance = !valid_s2 || !out_stall;
	assign fire = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign in_xfer = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign out_valid = valid_s2;
	assign region = region_s2;
	assign mapped_addr = mapped_s2;
	assign irq_line = irq_s2;

	always_comb begin
		size_lg = prg_size_log2_q;
		if (prg_size_log2_q > SIZE_LOG2_W'(MAX_BANKS_LOG2)) begin
			size_lg = SIZE_LOG2_W'(MAX_BANKS_LOG2);
		end
		for (int i = 0; i < MAX_BANKS_LOG2; i++) begin
			bank_mask[i] = (SIZE_LOG2_W'(i) < size_lg);
		end
	end

	assign bank_ext = MAX_BANKS_LOG2'({5'd0, bank_select_q});
	assign sel = addr_s1[15:12];
	assign lo_inc = irq_counter_q[7:0] + 8'd1;
	assign full_inc = irq_counter_q + CNT_W'(1);

	always_comb begin
		region_d = REGION_NONE;
		mapped_d = '0;
		latch_d = reload_latch_q;
		counter_d = irq_counter_q;
		counting_d = counting_on_q;
		enable_after_ack_d = enable_after_ack_q;
		byte_mode_d = byte_mode_q;
		bank_select_d = bank_select_q;
		pending_d = irq_pending_q;
		case (cmd_s1)
			CMD_READ: begin
				if (addr_s1[15:13] == 3'b011) begin
					region_d = REGION_RAM;
					mapped_d = MAPPED_W'(addr_s1[RAM_OFFSET_W-1:0]);
				end else if (addr_s1[15:14] == 2'b10) begin
					region_d = REGION_ROM;
					mapped_d = (MAPPED_W'(bank_ext & bank_mask) << BANK_SHIFT)
						| MAPPED_W'(addr_s1[BANK_SHIFT-1:0]);
				end else if (addr_s1[15:14] == 2'b11) begin
					region_d = REGION_ROM;
					mapped_d = (MAPPED_W'(bank_mask) << BANK_SHIFT)
						| MAPPED_W'(addr_s1[BANK_SHIFT-1:0]);
				end
			end
			CMD_WRITE: begin
				if (addr_s1[15:13] == 3'b011) begin
					region_d = REGION_RAM;
					mapped_d = MAPPED_W'(addr_s1[RAM_OFFSET_W-1:0]);
				end else begin
					case (sel)
						SEL_LATCH0: latch_d[3:0] = wdata_s1[3:0];
						SEL_LATCH1: latch_d[7:4] = wdata_s1[3:0];
						SEL_LATCH2: latch_d[11:8] = wdata_s1[3:0];
						SEL_LATCH3: latch_d[15:12] = wdata_s1[3:0];
						SEL_CONTROL: begin
							pending_d = 1'b0;
							counting_d = wdata_s1[CTRL_COUNTING];
							enable_after_ack_d = wdata_s1[CTRL_ENABLE_AFTER_ACK];
							byte_mode_d = wdata_s1[CTRL_BYTE_MODE];
							if (wdata_s1[CTRL_COUNTING]) begin
								counter_d = reload_latch_q;
							end
						end
						SEL_ACK: begin
							pending_d = 1'b0;
							counting_d = enable_after_ack_q;
						end
						SEL_BANK: bank_select_d = wdata_s1[BANK_SEL_W-1:0];
						default: ;
					endcase
				end
			end
			CMD_TICK: begin
				if (counting_on_q) begin
					if (byte_mode_q) begin
						if (lo_inc == 8'd0) begin
							pending_d = 1'b1;
							counter_d[7:0] = reload_latch_q[7:0];
						end else begin
							counter_d[7:0] = lo_inc;
						end
					end else begin
						if (full_inc == '0) begin
							pending_d = 1'b1;
							counter_d = reload_latch_q;
						end else begin
							counter_d = full_inc;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			prg_size_log2_q <= PRG_SIZE_LOG2_RST;
			reload_latch_q <= '0;
			irq_counter_q <= '0;
			counting_on_q <= 1'b0;
			enable_after_ack_q <= 1'b0;
			byte_mode_q <= 1'b0;
			bank_select_q <= '0;
			irq_pending_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				prg_size_log2_q <= cfg_data;
			end
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (fire) begin
				reload_latch_q <= latch_d;
				irq_counter_q <= counter_d;
				counting_on_q <= counting_d;
				enable_after_ack_q <= enable_after_ack_d;
				byte_mode_q <= byte_mode_d;
				bank_select_q <= bank_select_d;
				irq_pending_q <= pending_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_s1 <= cmd;
			addr_s1 <= cpu_addr;
			wdata_s1 <= wdata;
		end
		if (fire) begin
			region_s2 <= region_d;
			mapped_s2 <= mapped_d;
			irq_s2 <= pending_d;
		end
	end

	`CBIC_ASSERT_SAME(a_stall_only_when_full, in_stall,
		valid_s1 && valid_s2 && out_stall, "Input stalled without a held result.")
	`CBIC_ASSERT_SAME(a_none_has_zero_offset, valid_s2 && region_s2 == REGION_NONE,
		mapped_s2 == '0, "Result with no memory access carries a nonzero offset.")
	`CBIC_ASSERT_SAME(a_ram_offset_range, valid_s2 && region_s2 == REGION_RAM,
		mapped_s2[MAPPED_W-1:RAM_OFFSET_W] == '0, "Work RAM offset out of range.")
	`CBIC_ASSERT_NEXT(a_irq_rises_on_tick, !(fire && cmd_s1 == CMD_TICK),
		!$rose(irq_pending_q), "IRQ raised by something other than a tick.")
	`CBIC_ASSERT_NEXT(a_state_holds_idle, !fire,
		$stable(irq_counter_q) && $stable(reload_latch_q), "IRQ state changed with no transfer.")

endmodule
